>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/olas_pkg.sv
// Package with the sizes, codes and cell control type of the ordered list unit.
package olas_pkg;

	localparam int POS_W = 4;
	localparam int IDX_W = POS_W;
	localparam int CAPACITY = 1 << POS_W;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DATA_W = 32;
	localparam int OP_W = 3;
	localparam int ST_W = 2;
	localparam int IN_W = 40;
	localparam int OUT_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_REMOVE = 3'd1,
		OP_FIND   = 3'd2,
		OP_READ   = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic              append_en;
		logic              remove_en;
		logic [IDX_W-1:0]  position;
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] value;
	} cell_ctrl_t;

endpackage

>>> rtl/core/olas_cell.sv
// One storage cell of the list: loads an appended value, shifts from its upper neighbor, compares.
module olas_cell
	import olas_pkg::*;
(
	input  logic              clk,
	input  logic [IDX_W-1:0]  idx,
	input  cell_ctrl_t        ctrl,
	input  logic [DATA_W-1:0] upper_data,
	output logic [DATA_W-1:0] data,
	output logic              match
);

	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  idx_ext;
	logic              in_use;
	logic              load;
	logic              shift;

	assign idx_ext = CNT_W'(idx);
	assign in_use = idx_ext < ctrl.count;
	assign load = ctrl.append_en && (idx_ext == ctrl.count);
	assign shift = ctrl.remove_en && (idx >= ctrl.position) &&
		((idx_ext + CNT_W'(1)) < ctrl.count);

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= ctrl.value;
		end else if (shift) begin
			data_q <= upper_data;
		end
	end

	assign data = data_q;
	assign match = in_use && (data_q == ctrl.value);

endmodule

>>> rtl/core/ordered_list_append_remove_search_unit.sv
// Top level of the ordered list unit: request decode, chain of cells and result register.
// The list holds up to 16 signed 32-bit entries in a row of cells. Each request appends,
// removes with gap closing, finds the lowest matching index, reads at an index, or clears;
// every request returns exactly one result. All cells compare and shift in the cycle of
// acceptance, so a request is taken every cycle and its result appears in the output
// register on the next cycle; the single output register sets the rate to one request per
// cycle while m_tready stays high, and a stalled result holds off new requests.
module ordered_list_append_remove_search_unit
	import olas_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// op[2:0], position[6:3], value[38:7], zero fill
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// read_value[31:0], found_index[35:32], found[36], entry_count[41:37], status[43:42], zero fill
	output logic [OUT_W-1:0] m_tdata
);

	op_t                      op;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     accept;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  next_count;
	cell_ctrl_t        ctrl;
	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0] match;

	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic [DATA_W-1:0] rd_value;
	logic [IDX_W-1:0]  fnd_idx;
	logic              fnd;
	logic [ST_W-1:0]   status;
	logic              append_req;
	logic              remove_req;

	logic                     m_valid_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic [IDX_W-1:0]         found_index_q;
	logic                     found_q;
	logic [CNT_W-1:0]         entry_count_q;
	logic [ST_W-1:0]          status_q;

	assign op = op_t'(s_tdata[OP_W-1:0]);
	assign position = s_tdata[OP_W+POS_W-1:OP_W];
	assign value = s_tdata[OP_W+POS_W+DATA_W-1:OP_W+POS_W];

	assign s_tready = !m_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	assign ctrl.append_en = accept && append_req;
	assign ctrl.remove_en = accept && remove_req;
	assign ctrl.position = position;
	assign ctrl.count = count_q;
	assign ctrl.value = value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i < CAPACITY - 1) begin : g_mid
			olas_cell u_cell (
				.clk        (clk),
				.idx        (IDX_W'(i)),
				.ctrl       (ctrl),
				.upper_data (cell_data[i+1]),
				.data       (cell_data[i]),
				.match      (match[i])
			);
		end else begin : g_last
			olas_cell u_cell (
				.clk        (clk),
				.idx        (IDX_W'(i)),
				.ctrl       (ctrl),
				.upper_data (cell_data[i]),
				.data       (cell_data[i]),
				.match      (match[i])
			);
		end
	end

	always_comb begin
		hit = |match;
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		rd_value = '0;
		fnd_idx = '0;
		fnd = 1'b0;
		status = ST_OK;
		append_req = 1'b0;
		remove_req = 1'b0;
		next_count = count_q;
		case (op)
			OP_APPEND: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					status = ST_FULL;
				end else begin
					append_req = 1'b1;
					next_count = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (CNT_W'(position) >= count_q) begin
					status = ST_RANGE;
				end else begin
					remove_req = 1'b1;
					next_count = count_q - CNT_W'(1);
				end
			end
			OP_FIND: begin
				fnd = hit;
				fnd_idx = hit ? hit_idx : '0;
				status = hit ? ST_OK : ST_MISS;
			end
			OP_READ: begin
				if (CNT_W'(position) >= count_q) begin
					status = ST_RANGE;
				end else begin
					rd_value = cell_data[position];
				end
			end
			OP_CLEAR: begin
				next_count = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= next_count;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_value;
			found_index_q <= fnd_idx;
			found_q <= fnd;
			entry_count_q <= next_count;
			status_q <= status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {4'b0, status_q, entry_count_q, found_q, found_index_q, read_value_q};

endmodule

>>> rtl/core/olas_checker.sv
// Port-level checker for the ordered list unit and its bind to the top level.
`include "assert_macros.svh"

module olas_checker
	import olas_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	// read_value[31:0], found_index[35:32], found[36], entry_count[41:37], status[43:42], zero fill
	input logic [OUT_W-1:0] m_tdata
);

	logic             stall;
	logic [CNT_W-1:0] cnt;
	logic [ST_W-1:0]  st;
	logic             fnd;

	assign stall = m_tvalid && !m_tready;
	assign cnt = m_tdata[41:37];
	assign st = m_tdata[43:42];
	assign fnd = m_tdata[36];

	// A stalled result keeps its value until it is taken.
	`ASSERT_NEXT(a_hold, clk, arst_n, stall, m_tvalid && $stable(m_tdata))
	// No new request is taken while a result waits.
	`ASSERT_IMPL(a_backpressure, clk, arst_n, stall, !s_tready)
	// The count never exceeds the capacity.
	`ASSERT_IMPL(a_count_range, clk, arst_n, m_tvalid, cnt <= CNT_W'(CAPACITY))
	// A full status only arises with the list at capacity.
	`ASSERT_IMPL(a_full_count, clk, arst_n, m_tvalid && (st == ST_FULL), cnt == CNT_W'(CAPACITY))
	// A successful search reports ok and a match inside the list.
	`ASSERT_IMPL(a_found_ok, clk, arst_n, m_tvalid && fnd, (st == ST_OK) && (cnt != '0))

endmodule

bind ordered_list_append_remove_search_unit olas_checker u_olas_checker (.*);
